// ===== rtl/paged_allocator_and_translator_defines.svh =====
// Assertion macros used by the top-level RTL file.
// Define NO_ASSERTIONS to compile them away.
`ifndef PAGED_ALLOCATOR_AND_TRANSLATOR_DEFINES_SVH
`define PAGED_ALLOCATOR_AND_TRANSLATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define PAT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
// The consequent must hold in the cycle after the antecedent.
`define PAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define PAT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PAT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/pat_pkg.sv =====
package pat_pkg;

  localparam int unsigned OFFSET_BITS_DEF          = 10;
  localparam int unsigned VIRTUAL_ADDRESS_BITS_DEF = 20;
  localparam int unsigned FRAME_COUNT_DEF          = 1024;
  localparam int unsigned PROCESS_COUNT_DEF        = 8;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned PID_W  = 4;
  localparam int unsigned SIZE_W = 21;
  localparam int unsigned VA_W   = 20;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned STS_W  = 2;

  localparam logic [VA_W-1:0] FIRST_BREAK_RST = VA_W'(1024);

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

  localparam logic [STS_W-1:0] STS_OK       = 2'd0;
  localparam logic [STS_W-1:0] STS_UNMAPPED = 2'd1;
  localparam logic [STS_W-1:0] STS_NO_RUN   = 2'd2;
  localparam logic [STS_W-1:0] STS_NO_SPACE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [PID_W-1:0]  process_id;
    logic [SIZE_W-1:0] alloc_size;
    logic [VA_W-1:0]   virtual_address;
    logic [DATA_W-1:0] write_data;
  } in_t;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [VA_W-1:0]   alloc_address;
    logic [DATA_W-1:0] read_data;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_CHECK,
    ST_MAP,
    ST_TRANS,
    ST_READ
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic             clr_step;
    logic             load;
    logic             scan_init;
    logic             scan_step;
    logic             map_step;
    logic             commit;
    logic             ram_wr;
    logic             fin;
    logic [STS_W-1:0] fin_status;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic             clr_last;
    logic [CMD_W-1:0] command;
    logic             pid_bad;
    logic             va_oob;
    logic             pages_big;
    logic             pages_zero;
    logic             found;
    logic             exhausted;
    logic             over;
    logic             map_last;
    logic             map_hit;
  } dp_sts_t;

endpackage

// ===== rtl/paged_allocator_and_translator.sv =====
// Channel   Ports                              Transfer
// command   start, busy, cmd_i                 start high while busy low
// result    done_o, result_o                   one cycle strobe, no backpressure
// config    cfg_we_i, cfg_wdata_i              write enable, taken at once
//
// After reset a clearing pass zeroes the owner map, the page map and the byte RAM,
// one entry per cycle; busy stays high, config is taken.
// From acceptance to the result strobe: a read or write does a page map lookup, then a
// byte RAM access; an allocate scans the frames, then maps its pages, and a zero-size
// request skips both. The receiver cannot stall the result strobe, and the next
// transaction may be taken in the cycle in which the previous result is shown.

`include "paged_allocator_and_translator_defines.svh"

module paged_allocator_and_translator #(
  parameter int unsigned OFFSET_BITS          = pat_pkg::OFFSET_BITS_DEF,
  parameter int unsigned VIRTUAL_ADDRESS_BITS = pat_pkg::VIRTUAL_ADDRESS_BITS_DEF,
  parameter int unsigned FRAME_COUNT          = pat_pkg::FRAME_COUNT_DEF,
  parameter int unsigned PROCESS_COUNT        = pat_pkg::PROCESS_COUNT_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  pat_pkg::in_t             cmd_i,
  output logic                     done_o,
  output pat_pkg::out_t            result_o,
  input  logic                     cfg_we_i,
  input  logic [pat_pkg::VA_W-1:0] cfg_wdata_i
);

  // The controller sequences each transaction; the datapath holds the maps,
  // the break pointers and the byte store.
  pat_pkg::ctrl_cmd_t ctl;
  pat_pkg::dp_sts_t   sts;

  pat_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (ctl)
  );

  pat_datapath #(
    .OFFSET_BITS          (OFFSET_BITS),
    .VIRTUAL_ADDRESS_BITS (VIRTUAL_ADDRESS_BITS),
    .FRAME_COUNT          (FRAME_COUNT),
    .PROCESS_COUNT        (PROCESS_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  // An accepted transaction keeps the block busy in the next cycle.
  `PAT_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  // A result only follows a cycle in which the block was working.
  `PAT_ASSERT_IMPL(a_done_after_busy, clk_i, rst_ni, done_o, $past(busy))
  // A nonzero region address is only reported with a good status.
  `PAT_ASSERT_IMPL(a_addr_ok, clk_i, rst_ni, done_o && result_o.alloc_address != '0,
                   result_o.status == pat_pkg::STS_OK)
  // Read data is zero unless the status is good.
  `PAT_ASSERT_IMPL(a_rdata_ok, clk_i, rst_ni, done_o && result_o.read_data != '0,
                   result_o.status == pat_pkg::STS_OK)

endmodule

// ===== rtl/pat_ram.sv =====
module pat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pat_ctrl.sv =====
module pat_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  pat_pkg::dp_sts_t   sts_i,
  output pat_pkg::ctrl_cmd_t cmd_o
);

  pat_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pat_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != pat_pkg::ST_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pat_pkg::ST_CLEAR: begin
        if (sts_i.clr_last) state_d = pat_pkg::ST_IDLE;
      end
      pat_pkg::ST_IDLE: begin
        if (start) state_d = pat_pkg::ST_DISPATCH;
      end
      pat_pkg::ST_DISPATCH: begin
        state_d = pat_pkg::ST_IDLE;
        if (sts_i.command == pat_pkg::CMD_ALLOC) begin
          if (!sts_i.pid_bad && !sts_i.pages_big) begin
            state_d = sts_i.pages_zero ? pat_pkg::ST_CHECK : pat_pkg::ST_SCAN;
          end
        end else if (sts_i.command == pat_pkg::CMD_READ ||
                     sts_i.command == pat_pkg::CMD_WRITE) begin
          if (!sts_i.pid_bad && !sts_i.va_oob) state_d = pat_pkg::ST_TRANS;
        end
      end
      pat_pkg::ST_SCAN: begin
        if (sts_i.found) state_d = pat_pkg::ST_CHECK;
        else if (sts_i.exhausted) state_d = pat_pkg::ST_IDLE;
      end
      pat_pkg::ST_CHECK: begin
        if (sts_i.over || sts_i.pages_zero) state_d = pat_pkg::ST_IDLE;
        else state_d = pat_pkg::ST_MAP;
      end
      pat_pkg::ST_MAP: begin
        if (sts_i.map_last) state_d = pat_pkg::ST_IDLE;
      end
      pat_pkg::ST_TRANS: begin
        if (sts_i.map_hit && sts_i.command == pat_pkg::CMD_READ) state_d = pat_pkg::ST_READ;
        else state_d = pat_pkg::ST_IDLE;
      end
      pat_pkg::ST_READ: state_d = pat_pkg::ST_IDLE;
      default: state_d = pat_pkg::ST_CLEAR;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      pat_pkg::ST_CLEAR: cmd_o.clr_step = 1'b1;
      pat_pkg::ST_IDLE: cmd_o.load = start;
      pat_pkg::ST_DISPATCH: begin
        if (sts_i.command == pat_pkg::CMD_ALLOC) begin
          if (sts_i.pid_bad) begin
            cmd_o.fin        = 1'b1;
            cmd_o.fin_status = pat_pkg::STS_NO_SPACE;
          end else if (sts_i.pages_big) begin
            cmd_o.fin        = 1'b1;
            cmd_o.fin_status = pat_pkg::STS_NO_RUN;
          end else if (!sts_i.pages_zero) begin
            cmd_o.scan_init = 1'b1;
          end
        end else if (sts_i.command == pat_pkg::CMD_READ ||
                     sts_i.command == pat_pkg::CMD_WRITE) begin
          if (sts_i.pid_bad || sts_i.va_oob) begin
            cmd_o.fin        = 1'b1;
            cmd_o.fin_status = pat_pkg::STS_UNMAPPED;
          end
        end else begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = pat_pkg::STS_OK;
        end
      end
      pat_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (!sts_i.found && sts_i.exhausted) begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = pat_pkg::STS_NO_RUN;
        end
      end
      pat_pkg::ST_CHECK: begin
        if (sts_i.over) begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = pat_pkg::STS_NO_SPACE;
        end else if (sts_i.pages_zero) begin
          cmd_o.commit     = 1'b1;
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = pat_pkg::STS_OK;
        end
      end
      pat_pkg::ST_MAP: begin
        cmd_o.map_step = 1'b1;
        if (sts_i.map_last) begin
          cmd_o.commit     = 1'b1;
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = pat_pkg::STS_OK;
        end
      end
      pat_pkg::ST_TRANS: begin
        if (!sts_i.map_hit) begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = pat_pkg::STS_UNMAPPED;
        end else if (sts_i.command == pat_pkg::CMD_WRITE) begin
          cmd_o.ram_wr     = 1'b1;
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = pat_pkg::STS_OK;
        end
      end
      pat_pkg::ST_READ: begin
        cmd_o.fin        = 1'b1;
        cmd_o.fin_status = pat_pkg::STS_OK;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== rtl/pat_datapath.sv =====
module pat_datapath #(
  parameter int unsigned OFFSET_BITS          = pat_pkg::OFFSET_BITS_DEF,
  parameter int unsigned VIRTUAL_ADDRESS_BITS = pat_pkg::VIRTUAL_ADDRESS_BITS_DEF,
  parameter int unsigned FRAME_COUNT          = pat_pkg::FRAME_COUNT_DEF,
  parameter int unsigned PROCESS_COUNT        = pat_pkg::PROCESS_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pat_pkg::VA_W-1:0]      cfg_wdata_i,
  input  pat_pkg::in_t                  cmd_i,
  input  pat_pkg::ctrl_cmd_t            ctl_i,
  output pat_pkg::dp_sts_t              sts_o,
  output logic                          done_o,
  output pat_pkg::out_t                 result_o
);

  localparam int unsigned FW     = $clog2(FRAME_COUNT);
  localparam int unsigned IW     = $clog2(FRAME_COUNT + 1);
  localparam int unsigned PW     = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
  localparam int unsigned VPN_W  = VIRTUAL_ADDRESS_BITS - OFFSET_BITS;
  localparam int unsigned MW     = PW + VPN_W;
  localparam int unsigned MAP_D  = PROCESS_COUNT << VPN_W;
  localparam int unsigned BAW    = FW + OFFSET_BITS;
  localparam int unsigned RAM_D  = FRAME_COUNT << OFFSET_BITS;
  localparam int unsigned CW     = (BAW > MW) ? BAW : MW;
  localparam int unsigned BPW    = ((VIRTUAL_ADDRESS_BITS > pat_pkg::VA_W) ?
                                    VIRTUAL_ADDRESS_BITS : pat_pkg::VA_W) + 1;
  localparam int unsigned EW     = BPW + 2;
  localparam int unsigned PGW    = pat_pkg::SIZE_W + 1 - OFFSET_BITS;
  localparam int unsigned SUMW   = pat_pkg::SIZE_W + 1;

  localparam logic [BPW-1:0] VSPACE    = BPW'(1) << VIRTUAL_ADDRESS_BITS;
  localparam logic [BPW-1:0] PAGE_MASK = (BPW'(1) << OFFSET_BITS) - BPW'(1);

  // Configuration and per-process break pointers.
  logic [pat_pkg::VA_W-1:0] first_break_q;
  logic [BPW-1:0]           brk_q [PROCESS_COUNT];
  logic [PROCESS_COUNT-1:0] started_q;

  // Captured transaction.
  logic [pat_pkg::CMD_W-1:0]  command_q;
  logic [pat_pkg::PID_W-1:0]  pid_q;
  logic [PW-1:0]              p_q;
  logic                       pid_bad_q;
  logic [BPW-1:0]             va_q;
  logic [pat_pkg::DATA_W-1:0] wdata_q;
  logic [PGW-1:0]             pages_q;
  logic [BPW-1:0]             bp_q;

  // Scan and map state.
  logic [CW-1:0]  clr_q;
  logic [IW-1:0]  idx_q, cnt_q, k_q;
  logic [FW-1:0]  rd_idx_q, start_q;
  logic           vld_q, found_q;

  logic                       done_q;
  pat_pkg::out_t              result_q;

  logic [PW-1:0]      p_in;
  logic [BPW-1:0]     va_in;
  logic [SUMW-1:0]    size_sum;
  logic [BPW-1:0]     bp_in;
  logic [EW-1:0]      end_addr;
  logic [FW-1:0]      frame_k;
  logic [VPN_W-1:0]   vpn_k;
  logic [FW:0]        map_rdata;
  logic [pat_pkg::PID_W-1:0] own_rdata;
  logic [pat_pkg::DATA_W-1:0] ram_rdata;
  logic               own_we, map_we, ram_we;
  logic [FW-1:0]      own_addr;
  logic [MW-1:0]      map_addr;
  logic [BAW-1:0]     ram_addr;
  logic [pat_pkg::PID_W-1:0]  own_wdata;
  logic [FW:0]        map_wdata;
  logic [pat_pkg::DATA_W-1:0] ram_wdata;

  assign p_in     = PW'(cmd_i.process_id - pat_pkg::PID_W'(1));
  assign va_in    = BPW'(cmd_i.virtual_address);
  assign size_sum = SUMW'(cmd_i.alloc_size) + SUMW'(PAGE_MASK);
  assign bp_in    = started_q[p_in] ? brk_q[p_in]
                                    : (BPW'(first_break_q) & ~PAGE_MASK);
  assign end_addr = EW'(bp_q) + (EW'(pages_q) << OFFSET_BITS);
  assign frame_k  = start_q + k_q[FW-1:0];
  assign vpn_k    = bp_q[VIRTUAL_ADDRESS_BITS-1:OFFSET_BITS] + VPN_W'(k_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_break_q <= pat_pkg::FIRST_BREAK_RST;
      started_q     <= '0;
      clr_q         <= '0;
      done_q        <= 1'b0;
    end else begin
      if (cfg_we_i) first_break_q <= cfg_wdata_i;
      if (ctl_i.clr_step) clr_q <= clr_q + CW'(1);
      if (ctl_i.commit) started_q[p_q] <= 1'b1;
      done_q <= ctl_i.fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      command_q <= cmd_i.command;
      pid_q     <= cmd_i.process_id;
      p_q       <= p_in;
      pid_bad_q <= (cmd_i.process_id == '0) ||
                   (32'(cmd_i.process_id) > PROCESS_COUNT);
      va_q      <= va_in;
      wdata_q   <= cmd_i.write_data;
      pages_q   <= size_sum[SUMW-1:OFFSET_BITS];
      bp_q      <= bp_in;
    end
    if (ctl_i.commit) brk_q[p_q] <= end_addr[BPW-1:0];
    if (ctl_i.scan_init) begin
      idx_q   <= '0;
      cnt_q   <= '0;
      k_q     <= '0;
      vld_q   <= 1'b0;
      found_q <= 1'b0;
    end else if (ctl_i.scan_step) begin
      if (32'(idx_q) != FRAME_COUNT) begin
        idx_q    <= idx_q + IW'(1);
        rd_idx_q <= idx_q[FW-1:0];
        vld_q    <= 1'b1;
      end else begin
        vld_q <= 1'b0;
      end
      if (vld_q && !found_q) begin
        if (own_rdata == '0) begin
          cnt_q <= cnt_q + IW'(1);
          if (32'(cnt_q) + 32'd1 == 32'(pages_q)) begin
            found_q <= 1'b1;
            start_q <= rd_idx_q - cnt_q[FW-1:0];
          end
        end else begin
          cnt_q <= '0;
        end
      end
    end
    if (ctl_i.map_step) k_q <= k_q + IW'(1);
    if (ctl_i.fin) begin
      result_q.status        <= ctl_i.fin_status;
      result_q.alloc_address <= (command_q == pat_pkg::CMD_ALLOC &&
                                 ctl_i.fin_status == pat_pkg::STS_OK) ?
                                bp_q[pat_pkg::VA_W-1:0] : '0;
      result_q.read_data     <= (command_q == pat_pkg::CMD_READ &&
                                 ctl_i.fin_status == pat_pkg::STS_OK) ? ram_rdata : '0;
    end
  end

  // Memory ports. The clearing pass writes zeros everywhere after reset.
  always_comb begin
    if (ctl_i.clr_step) begin
      own_addr  = clr_q[FW-1:0];
      own_we    = (32'(clr_q) < FRAME_COUNT);
      own_wdata = '0;
      map_addr  = clr_q[MW-1:0];
      map_we    = (32'(clr_q) < MAP_D);
      map_wdata = '0;
      ram_addr  = clr_q[BAW-1:0];
      ram_we    = (32'(clr_q) < RAM_D);
      ram_wdata = '0;
    end else begin
      own_addr  = ctl_i.map_step ? frame_k : idx_q[FW-1:0];
      own_we    = ctl_i.map_step;
      own_wdata = pid_q;
      map_addr  = ctl_i.map_step ? {p_q, vpn_k}
                                 : {p_q, va_q[VIRTUAL_ADDRESS_BITS-1:OFFSET_BITS]};
      map_we    = ctl_i.map_step;
      map_wdata = {1'b1, frame_k};
      ram_addr  = {map_rdata[FW-1:0], va_q[OFFSET_BITS-1:0]};
      ram_we    = ctl_i.ram_wr;
      ram_wdata = wdata_q;
    end
  end

  pat_ram #(.WIDTH(pat_pkg::PID_W), .DEPTH(FRAME_COUNT)) u_owner (
    .clk_i(clk_i), .we_i(own_we), .addr_i(own_addr),
    .wdata_i(own_wdata), .rdata_o(own_rdata)
  );

  pat_ram #(.WIDTH(FW + 1), .DEPTH(MAP_D)) u_page_map (
    .clk_i(clk_i), .we_i(map_we), .addr_i(map_addr),
    .wdata_i(map_wdata), .rdata_o(map_rdata)
  );

  pat_ram #(.WIDTH(pat_pkg::DATA_W), .DEPTH(RAM_D)) u_byte_ram (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(ram_addr),
    .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  always_comb begin
    sts_o            = '0;
    sts_o.clr_last   = &clr_q;
    sts_o.command    = command_q;
    sts_o.pid_bad    = pid_bad_q;
    sts_o.va_oob     = (va_q >= VSPACE);
    sts_o.pages_big  = (32'(pages_q) > FRAME_COUNT);
    sts_o.pages_zero = (pages_q == '0);
    sts_o.found      = found_q;
    sts_o.exhausted  = (32'(idx_q) == FRAME_COUNT) && !vld_q && !found_q;
    sts_o.over       = (bp_q >= VSPACE) || (end_addr > EW'(VSPACE));
    sts_o.map_last   = (32'(k_q) + 32'd1 == 32'(pages_q));
    sts_o.map_hit    = map_rdata[FW];
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ===== sim/paged_allocator_and_translator_checker.sv =====
module paged_allocator_and_translator_checker
  import pat_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  in_t              cmd_i,
  input  logic             done_o,
  input  out_t             result_o,
  input  logic             cfg_we_i,
  input  logic [VA_W-1:0]  cfg_wdata_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               result_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGE = 1 << OFFSET_BITS_DEF;
  localparam int VPAGES = 1 << (VIRTUAL_ADDRESS_BITS_DEF - OFFSET_BITS_DEF);
  localparam int VSPACE = 1 << VIRTUAL_ADDRESS_BITS_DEF;

  logic [PID_W-1:0] frame_owner_m [FRAME_COUNT_DEF];
  int               brk_m [PROCESS_COUNT_DEF];
  bit               started_m [PROCESS_COUNT_DEF];
  bit               map_valid_m [PROCESS_COUNT_DEF*VPAGES];
  int               map_frame_m [PROCESS_COUNT_DEF*VPAGES];
  logic [7:0]       mem_m [int];
  logic [VA_W-1:0]  first_break_m;
  out_t             expected_q [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  function automatic logic [STS_W-1:0] alloc_pages(input int p, input int size,
                                                  output int addr);
    int pages, count, first, bp;
    bit found;
    pages = (size + PAGE - 1) >> OFFSET_BITS_DEF;
    count = 0;
    first = 0;
    found = (pages == 0);
    addr = 0;
    if (pages > FRAME_COUNT_DEF) return STS_NO_RUN;
    for (int i = 0; i < FRAME_COUNT_DEF && !found; i++) begin
      if (frame_owner_m[i] == 0) begin
        count++;
        if (count == pages) begin
          found = 1;
          first = i + 1 - count;
        end
      end else begin
        count = 0;
      end
    end
    if (!found) return STS_NO_RUN;
    bp = started_m[p] ? brk_m[p] : int'(first_break_m) & ~(PAGE - 1);
    if (bp >= VSPACE || bp + pages * PAGE > VSPACE) return STS_NO_SPACE;
    for (int k = 0; k < pages; k++) begin
      frame_owner_m[first + k] = PID_W'(p + 1);
      map_valid_m[p * VPAGES + (bp >> OFFSET_BITS_DEF) + k] = 1;
      map_frame_m[p * VPAGES + (bp >> OFFSET_BITS_DEF) + k] = first + k;
    end
    brk_m[p] = bp + pages * PAGE;
    started_m[p] = 1;
    addr = bp;
    return STS_OK;
  endfunction

  // Works out the result of one command and updates the shadow state.
  function automatic out_t translate_and_access(input in_t c);
    out_t r;
    int p, idx, phys, addr;
    bit pid_ok;
    r = '0;
    p = int'(c.process_id) - 1;
    pid_ok = c.process_id >= 1 && c.process_id <= PROCESS_COUNT_DEF;
    if (c.command == CMD_ALLOC) begin
      if (!pid_ok) begin
        r.status = STS_NO_SPACE;
      end else begin
        r.status = alloc_pages(p, int'(c.alloc_size), addr);
        if (r.status == STS_OK) r.alloc_address = VA_W'(addr);
      end
    end else if (c.command == CMD_READ || c.command == CMD_WRITE) begin
      idx = p * VPAGES + int'(c.virtual_address >> OFFSET_BITS_DEF);
      if (!pid_ok || !map_valid_m[idx]) begin
        r.status = STS_UNMAPPED;
      end else begin
        phys = (map_frame_m[idx] << OFFSET_BITS_DEF)
             | int'(c.virtual_address & VA_W'(PAGE - 1));
        if (c.command == CMD_READ)
          r.read_data = mem_m.exists(phys) ? mem_m[phys] : 8'h00;
        else
          mem_m[phys] = c.write_data;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      foreach (frame_owner_m[i]) frame_owner_m[i] = '0;
      foreach (brk_m[i]) begin
        brk_m[i] = 0;
        started_m[i] = 0;
      end
      foreach (map_valid_m[i]) map_valid_m[i] = 0;
      mem_m.delete();
      expected_q.delete();
      first_break_m = FIRST_BREAK_RST;
      fail_count_o = 0;
      result_count_o = 0;
      pending_o <= 0;
    end else begin
      // A result may show in the same cycle the next transaction is taken,
      // so the result is compared before the new prediction is queued.
      if (done_o) begin
        result_count_o++;
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing outstanding, status", result_o.status, 0);
        end else begin
          want = expected_q.pop_front();
          if (result_o.status !== want.status)
            report_mismatch("status", result_o.status, want.status);
          if (result_o.alloc_address !== want.alloc_address)
            report_mismatch("alloc_address", result_o.alloc_address, want.alloc_address);
          if (result_o.read_data !== want.read_data)
            report_mismatch("read_data", result_o.read_data, want.read_data);
        end
      end
      if (start && !busy) expected_q.push_back(translate_and_access(cmd_i));
      if (cfg_we_i) first_break_m = cfg_wdata_i;
      pending_o <= expected_q.size();
    end
  end
endmodule

// ===== sim/paged_allocator_and_translator_tb.sv =====
module paged_allocator_and_translator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pat_pkg::*;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  in_t             cmd_i = '0;
  logic            done_o;
  out_t            result_o;
  logic            cfg_we_i = 1'b0;
  logic [VA_W-1:0] cfg_wdata_i = '0;
  int              fail_count, pending, result_count;

  // Virtual page where each process's heap begins, noted when the first
  // allocate for it is issued, so reads and writes can aim at mapped pages.
  int heap_vpage [16];
  bit heap_known [16];
  int sent_alloc, sent_read, sent_write, sent_other;
  bit allow_gaps;

  always #6 clk_i = ~clk_i;

  paged_allocator_and_translator u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .cmd_i(cmd_i),
    .done_o(done_o), .result_o(result_o), .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  paged_allocator_and_translator_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .cmd_i(cmd_i),
    .done_o(done_o), .result_o(result_o), .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i), .fail_count_o(fail_count), .pending_o(pending),
    .result_count_o(result_count)
  );

  // Presents one transaction and holds it until the block takes it. Start is
  // left high so back-to-back transactions need no second assignment.
  task automatic issue(input logic [CMD_W-1:0] op, input int pid, input int size,
                       input int va, input int data);
    in_t c;
    c.command = op;
    c.process_id = PID_W'(pid);
    c.alloc_size = SIZE_W'(size);
    c.virtual_address = VA_W'(va);
    c.write_data = DATA_W'(data);
    if (op == CMD_ALLOC && !heap_known[pid & 15]) begin
      heap_known[pid & 15] = 1;
      heap_vpage[pid & 15] = int'(cfg_wdata_i) >> OFFSET_BITS_DEF;
    end
    case (op)
      CMD_ALLOC: sent_alloc++;
      CMD_READ:  sent_read++;
      CMD_WRITE: sent_write++;
      default:   sent_other++;
    endcase
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    // A random burst of idle cycles after some transactions.
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // Lowers start, waits until every result is in, then writes the register.
  task automatic set_first_break(input int value);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= VA_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One random transaction. Most target pages near the process's heap so that
  // reads and writes mostly hit mapped memory; a few use reserved process
  // numbers, the unused opcode or very large sizes.
  task automatic random_item(input int pid_lo, input int pid_hi);
    int pid, pick, size, va;
    pid = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15)
                                       : $urandom_range(pid_lo, pid_hi);
    pick = $urandom_range(0, 99);
    va = $urandom_range(0, (1 << VA_W) - 1);
    if (heap_known[pid] && $urandom_range(0, 9) != 0)
      va = (((heap_vpage[pid] + $urandom_range(0, 20)) & 1023) << OFFSET_BITS_DEF)
         | (va & 1023);
    if (pick < 30) begin
      case ($urandom_range(0, 19))
        0:       size = $urandom_range(0, (1 << SIZE_W) - 1);
        1:       size = $urandom_range(4096, 65536);
        default: size = $urandom_range(0, 3072);
      endcase
      issue(CMD_ALLOC, pid, size, va, $urandom_range(0, 255));
    end else if (pick < 62) begin
      issue(CMD_WRITE, pid, $urandom_range(0, (1 << SIZE_W) - 1), va, $urandom_range(0, 255));
    end else if (pick < 97) begin
      issue(CMD_READ, pid, $urandom_range(0, (1 << SIZE_W) - 1), va, $urandom_range(0, 255));
    end else begin
      issue(2'd3, pid, $urandom_range(0, (1 << SIZE_W) - 1), va, $urandom_range(0, 255));
    end
  endtask

  initial begin
    allow_gaps = 1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Highest first break: the heap of process 8 starts on the last page, so
    // one page fits and the next allocate, even of zero bytes, finds the
    // virtual space used up.
    set_first_break((1 << VA_W) - 1);
    issue(CMD_ALLOC, 8, 1, 0, 0);
    issue(CMD_ALLOC, 8, 1, 0, 0);
    issue(CMD_ALLOC, 8, 0, 0, 0);
    issue(CMD_WRITE, 8, 0, 'hFFC05, 'hA5);
    issue(CMD_READ, 8, 0, 'hFFC05, 0);
    issue(CMD_READ, 8, 0, 'hFFFFF, 0);
    issue(CMD_READ, 8, 0, 0, 0);
    // Reserved process numbers and the unused opcode change nothing.
    issue(CMD_ALLOC, 0, 1024, 0, 0);
    issue(CMD_READ, 9, 0, 'hFFC05, 0);
    issue(CMD_WRITE, 15, 0, 'hFFC05, 'h5A);
    issue(2'd3, 8, (1 << SIZE_W) - 1, 'hFFFFF, 'hFF);

    // Lowest first break, with the page rounding edges for process 1.
    set_first_break(0);
    issue(CMD_ALLOC, 1, 0, 0, 0);
    issue(CMD_ALLOC, 1, 1, 0, 0);
    issue(CMD_ALLOC, 1, 1024, 0, 0);
    issue(CMD_ALLOC, 1, 1025, 0, 0);
    issue(CMD_WRITE, 1, 0, 0, 'hFF);
    issue(CMD_WRITE, 1, 0, 'h00FFF, 'h00);
    issue(CMD_READ, 1, 0, 0, 0);
    issue(CMD_READ, 1, 0, 'h00FFF, 0);
    issue(CMD_READ, 1, 0, 'hFFFFF, 0);
    // Too many pages for any run, then a full-memory run that no longer fits
    // because some frames are already owned.
    issue(CMD_ALLOC, 1, (1 << SIZE_W) - 1, 0, 0);
    issue(CMD_ALLOC, 1, 1 << 20, 0, 0);

    set_first_break(1024);
    repeat (300) random_item(2, 5);
    set_first_break($urandom_range(0, (1 << VA_W) - 1));
    repeat (430) random_item(1, 8);
    // The last stretch runs without idle cycles.
    allow_gaps = 0;
    repeat (170) random_item(1, 8);

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d allocates, %0d reads, %0d writes and %0d other commands;",
             sent_alloc, sent_read, sent_write, sent_other);
    $display("%0d results compared under four first-break settings.", result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("paged_allocator_and_translator verification clean");
    end else begin
      $display("paged_allocator_and_translator verification failed");
    end
    $finish;
  end

  // The timeout allows for the clearing pass after reset and for a full frame
  // scan with mapping on an allocate.
  initial begin
    #200_000_000;
    $display("Timeout with %0d results outstanding.", pending);
    $display("paged_allocator_and_translator verification failed");
    $finish;
  end
endmodule
